[hdl/pscl_pkg.sv]
`timescale 1ns / 1ps

package pscl_pkg;

  localparam int NUM_SLOTS = 256;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int ADDR_W    = 32;
  localparam int COUNT_W   = 16;
  localparam int INDEX_W   = 8;
  localparam int VERDICT_W = 2;

  typedef logic [SLOT_W-1:0]  slot_idx_t;
  typedef logic [ADDR_W-1:0]  ip_addr_t;
  typedef logic [COUNT_W-1:0] conn_count_t;

  localparam slot_idx_t LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

  typedef enum logic {
    FUNC_OPEN  = 1'b0,
    FUNC_CLOSE = 1'b1
  } func_t;

  typedef enum logic [VERDICT_W-1:0] {
    V_ALLOW    = 2'd0,
    V_FORBID   = 2'd1,
    V_NOTFOUND = 2'd2
  } verdict_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    ip_addr_t    addr;
    conn_count_t count;
  } slot_t;

endpackage

[hdl/pscl_ifs.sv]
`timescale 1ns / 1ps

interface pscl_req_if;
  import pscl_pkg::*;
  logic     valid;
  logic     ready;
  logic     func;
  ip_addr_t src_addr;
  logic     is_internal;
  modport source(output valid, func, src_addr, is_internal, input ready);
  modport sink(input valid, func, src_addr, is_internal, output ready);
endinterface

interface pscl_rsp_if;
  import pscl_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [VERDICT_W-1:0] verdict;
  logic [INDEX_W-1:0]   slot_index;
  conn_count_t          new_count;
  modport source(output valid, verdict, slot_index, new_count, input ready);
  modport sink(input valid, verdict, slot_index, new_count, output ready);
endinterface

interface pscl_cfg_if;
  import pscl_pkg::*;
  logic        valid;
  logic        ready;
  conn_count_t max_per_host;
  modport source(output valid, max_per_host, input ready);
  modport sink(input valid, max_per_host, output ready);
endinterface

[hdl/per_source_connection_limiter_top.sv]
`timescale 1ns / 1ps

// channel | dir | beat                                  | handshake
// req     | in  | func, src_addr, is_internal           | valid/ready
// rsp     | out | verdict, slot_index, new_count        | valid/ready
// cfg     | in  | max_per_host                          | valid/ready
//
// an item scans the whole table through the
// single read port of the slot memory, one slot per cycle, then the chosen slot is written back if its count changes
// an open with limiting off skips the scan and touches no slot
// after rst a clearing pass zeroes every slot of the table, req not ready
// rsp is a register held until taken; the next req beat is taken meanwhile
// cfg is always ready

module per_source_connection_limiter_top (
  input logic              clk,
  input logic              rst,
  pscl_req_if.sink         req,
  pscl_rsp_if.source       rsp,
  pscl_cfg_if.sink         cfg
);
  import pscl_pkg::*;

  state_t      state, state_next;
  conn_count_t max_per_host;

  func_t       req_func;
  ip_addr_t    req_addr;
  logic        req_internal;

  slot_t       mem [NUM_SLOTS];
  slot_t       mem_q;
  logic        wr_en;
  slot_idx_t   wr_addr;
  slot_t       wr_data;

  slot_idx_t   clr_addr;
  slot_idx_t   rd_addr;
  logic        issue_done;
  logic        rd_vld;
  slot_idx_t   rd_slot;

  logic        match_found;
  slot_idx_t   match_slot;
  conn_count_t match_count;
  logic        free_found;
  slot_idx_t   free_slot;

  logic        rsp_valid;
  verdict_t    rsp_verdict;
  slot_idx_t   rsp_slot;
  conn_count_t rsp_count;

  logic        fin_ok;
  verdict_t    res_verdict;
  slot_idx_t   res_slot;
  conn_count_t res_count;

  logic        req_take;
  logic        hit_live;

  assign req.ready      = (state == ST_IDLE);
  assign cfg.ready      = 1'b1;
  assign req_take       = req.valid && req.ready;
  assign fin_ok         = !rsp_valid || rsp.ready;
  assign hit_live       = (mem_q.count != '0) && (mem_q.addr == req_addr);

  assign rsp.valid      = rsp_valid;
  assign rsp.verdict    = rsp_verdict;
  assign rsp.slot_index = INDEX_W'(rsp_slot);
  assign rsp.new_count  = rsp_count;

  // slot memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    wr_en       = 1'b0;
    wr_addr     = match_slot;
    wr_data     = '{addr: req_addr, count: match_count};
    res_verdict = V_ALLOW;
    res_slot    = '0;
    res_count   = '0;
    case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
        if (clr_addr == LAST_SLOT) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_take) begin
          if (func_t'(req.func) == FUNC_OPEN && max_per_host == '0) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (rd_vld && rd_slot == LAST_SLOT) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (req_func == FUNC_CLOSE) begin
          if (match_found) begin
            wr_en     = 1'b1;
            wr_data   = '{addr: req_addr, count: match_count - 1'b1};
            res_slot  = match_slot;
            res_count = match_count - 1'b1;
          end else begin
            res_verdict = V_NOTFOUND;
          end
        end else if (max_per_host == '0) begin
          res_verdict = V_ALLOW;
        end else if (!match_found) begin
          if (free_found) begin
            wr_en     = 1'b1;
            wr_addr   = free_slot;
            wr_data   = '{addr: req_addr, count: COUNT_W'(1)};
            res_slot  = free_slot;
            res_count = COUNT_W'(1);
          end else begin
            res_verdict = V_FORBID;
          end
        end else if (req_internal) begin
          res_slot  = match_slot;
          res_count = match_count;
        end else if (match_count >= max_per_host) begin
          res_verdict = V_FORBID;
          res_slot    = match_slot;
          res_count   = match_count;
        end else begin
          wr_en     = 1'b1;
          wr_data   = '{addr: req_addr, count: match_count + 1'b1};
          res_slot  = match_slot;
          res_count = match_count + 1'b1;
        end
        wr_en = wr_en && fin_ok;
        if (fin_ok) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_per_host <= '0;
    end else if (cfg.valid && cfg.ready) begin
      max_per_host <= cfg.max_per_host;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (req_take) begin
      req_func     <= func_t'(req.func);
      req_addr     <= req.src_addr;
      req_internal <= req.is_internal;
    end
  end

  // scan read issue
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_addr    <= '0;
      issue_done <= 1'b0;
      rd_vld     <= 1'b0;
    end else begin
      rd_vld <= (state == ST_SCAN) && !issue_done;
      if (req_take) begin
        rd_addr    <= '0;
        issue_done <= 1'b0;
      end else if (state == ST_SCAN && !issue_done) begin
        rd_addr <= rd_addr + 1'b1;
        if (rd_addr == LAST_SLOT) begin
          issue_done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_slot <= rd_addr;
  end

  // first live match and first free slot
  always_ff @(posedge clk) begin
    if (rst) begin
      match_found <= 1'b0;
      free_found  <= 1'b0;
    end else if (req_take) begin
      match_found <= 1'b0;
      free_found  <= 1'b0;
    end else if (rd_vld) begin
      if (hit_live && !match_found) begin
        match_found <= 1'b1;
      end
      if (mem_q.count == '0 && !free_found) begin
        free_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld && hit_live && !match_found) begin
      match_slot  <= rd_slot;
      match_count <= mem_q.count;
    end
    if (rd_vld && mem_q.count == '0 && !free_found) begin
      free_slot <= rd_slot;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == ST_FINISH && fin_ok) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && fin_ok) begin
      rsp_verdict <= res_verdict;
      rsp_slot    <= res_slot;
      rsp_count   <= res_count;
    end
  end

endmodule

[hdl/pscl_checker.sv]
`timescale 1ns / 1ps

module pscl_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           req_ready,
  input logic                           rsp_valid,
  input logic                           rsp_ready,
  input logic [pscl_pkg::VERDICT_W-1:0] rsp_verdict,
  input logic [pscl_pkg::INDEX_W-1:0]   rsp_slot_index,
  input pscl_pkg::conn_count_t          rsp_new_count
);
  import pscl_pkg::*;

  // table is being cleared right after reset
  a_clear_after_reset: assert property (
    @(posedge clk) disable iff (rst) $past(rst) |-> !req_ready
  ) else $error("req ready during clearing pass");

  a_verdict_code: assert property (
    @(posedge clk) disable iff (rst) rsp_valid |-> rsp_verdict != 2'd3
  ) else $error("undefined verdict");

  // a close that misses names no slot
  a_notfound_empty: assert property (
    @(posedge clk) disable iff (rst)
    rsp_valid && rsp_verdict == V_NOTFOUND |-> rsp_slot_index == '0 && rsp_new_count == '0
  ) else $error("not found beat carries a slot");

  a_rsp_hold: assert property (
    @(posedge clk) disable iff (rst) rsp_valid && !rsp_ready |=> rsp_valid
  ) else $error("rsp beat dropped while stalled");

endmodule

bind per_source_connection_limiter_top pscl_checker u_pscl_checker (
  .clk            (clk),
  .rst            (rst),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_verdict    (rsp.verdict),
  .rsp_slot_index (rsp.slot_index),
  .rsp_new_count  (rsp.new_count)
);
